// ----- hw/rtl/cale_pkg.sv -----
// Package for the credit/acknowledge link endpoint.
// Holds the channel payload types, result codes and reset constants.
// No dependencies; every module of the block imports it.
package cale_pkg;

  localparam logic [7:0]  ACK_MARK = 8'hFF;
  localparam logic [31:0] RESET_INITIAL_INTERVAL = 32'd16;
  localparam logic [31:0] RESET_RX_ACK_INTERVAL = 32'd32;
  localparam logic [31:0] RESET_LENGTH_LIMIT = 32'd1000000;
  localparam logic [2:0]  HEADER_LAST = 3'd4;
  localparam logic [2:0]  ACK_LAST = 3'd4;
  localparam logic [2:0]  ACK_BEATS = 3'd5;
  localparam int          QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_XMIT,
    KIND_PACKET,
    KIND_ACK,
    KIND_FAULT
  } kind_t;

  typedef enum logic [1:0] {
    PART_COMMAND,
    PART_LENGTH,
    PART_PAYLOAD
  } part_t;

  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_LENGTH,
    FAULT_MARKER,
    FAULT_REFUSED,
    FAULT_HALTED
  } fault_t;

  typedef enum logic [1:0] {
    CFG_INITIAL_INTERVAL,
    CFG_RX_ACK_INTERVAL,
    CFG_LENGTH_LIMIT
  } cfg_index_t;

  typedef enum logic {
    RX_HEADER,
    RX_PAYLOAD
  } rx_phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    part_t      part;
    logic       packet_end;
    fault_t     fault_code;
    logic       last;
  } out_item_t;

  // One queue entry: the final result of an item, optionally preceded by
  // a five-byte acknowledge burst.
  typedef struct packed {
    logic       ack_burst;
    kind_t      kind;
    logic [7:0] data;
    part_t      part;
    logic       packet_end;
    fault_t     fault_code;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hw/rtl/cale_front.sv -----
// Front end of the link endpoint: configuration registers, receive deframer,
// credit tracking and acknowledge parser. Classifies each item that yields a
// result into a queue entry. Depends on cale_pkg.
module cale_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cale_pkg::in_item_t      in_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  cale_pkg::queue_status_t q_stat,
  output logic                    push,
  output cale_pkg::entry_t        push_entry,
  output logic [31:0]             rx_ack_interval
);
  import cale_pkg::*;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [7:0] b, logic [1:0] lane);
    put_byte = w | ({24'd0, b} << {lane, 3'b000});
  endfunction

  logic [31:0] length_limit, length_limit_next;
  logic [31:0] rx_ack_interval_next;
  rx_phase_t   rx_phase, rx_phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [31:0] length_word, length_word_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] rx_ack_countdown, rx_ack_countdown_next;
  logic [31:0] tx_credit, tx_credit_next;
  logic        awaiting_ack, awaiting_ack_next;
  logic [2:0]  ack_index, ack_index_next;
  logic [31:0] ack_value, ack_value_next;
  logic        halted, halted_next;

  logic        accept;
  logic        cfg_write;
  logic        rx_expire;
  logic [31:0] length_acc;
  logic [31:0] ack_acc;
  logic        length_over;

  assign in_stall    = q_stat.full;
  assign cfg_ready   = !in_valid;
  assign accept      = in_valid && !q_stat.full;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign rx_expire   = rx_ack_countdown <= 32'd1;
  assign length_acc  = put_byte(length_word, in_item.data_byte, 2'(header_index - 3'd1));
  assign ack_acc     = put_byte(ack_value, in_item.data_byte, 2'(ack_index - 3'd1));
  assign length_over = length_acc > length_limit;

  always_comb begin
    length_limit_next      = length_limit;
    rx_ack_interval_next   = rx_ack_interval;
    rx_phase_next          = rx_phase;
    header_index_next      = header_index;
    length_word_next       = length_word;
    payload_remaining_next = payload_remaining;
    rx_ack_countdown_next  = rx_ack_countdown;
    tx_credit_next         = tx_credit;
    awaiting_ack_next      = awaiting_ack;
    ack_index_next         = ack_index;
    ack_value_next         = ack_value;
    halted_next            = halted;
    if (cfg_write) begin
      case (cfg_index)
        CFG_INITIAL_INTERVAL: begin
          tx_credit_next        = cfg_data;
          rx_ack_countdown_next = cfg_data;
        end
        CFG_RX_ACK_INTERVAL: rx_ack_interval_next = cfg_data;
        CFG_LENGTH_LIMIT:    length_limit_next = cfg_data;
        default: ;
      endcase
    end else if (accept && !halted) begin
      if (in_item.opcode) begin
        if (!awaiting_ack) begin
          if (tx_credit <= 32'd1) begin
            tx_credit_next    = '0;
            awaiting_ack_next = 1'b1;
            ack_index_next    = '0;
          end else begin
            tx_credit_next = tx_credit - 32'd1;
          end
        end
      end else if (awaiting_ack) begin
        if (ack_index == 3'd0) begin
          if (in_item.data_byte != ACK_MARK) begin
            halted_next = 1'b1;
          end else begin
            ack_value_next = '0;
            ack_index_next = 3'd1;
          end
        end else begin
          ack_value_next = ack_acc;
          if (ack_index >= ACK_LAST) begin
            ack_index_next    = '0;
            tx_credit_next    = ack_acc;
            awaiting_ack_next = ack_acc == 32'd0;
          end else begin
            ack_index_next = ack_index + 3'd1;
          end
        end
      end else begin
        rx_ack_countdown_next = rx_expire ? rx_ack_interval : rx_ack_countdown - 32'd1;
        if (rx_phase == RX_HEADER) begin
          if (header_index == 3'd0) begin
            length_word_next  = '0;
            header_index_next = 3'd1;
          end else begin
            length_word_next = length_acc;
            if (header_index < HEADER_LAST) begin
              header_index_next = header_index + 3'd1;
            end else begin
              header_index_next = '0;
              if (length_over) begin
                halted_next = 1'b1;
              end else if (length_acc != 32'd0) begin
                payload_remaining_next = length_acc;
                rx_phase_next          = RX_PAYLOAD;
              end
            end
          end
        end else if (payload_remaining <= 32'd1) begin
          payload_remaining_next = '0;
          rx_phase_next          = RX_HEADER;
        end else begin
          payload_remaining_next = payload_remaining - 32'd1;
        end
      end
    end
  end

  always_comb begin
    push                  = 1'b0;
    push_entry.ack_burst  = 1'b0;
    push_entry.kind       = KIND_XMIT;
    push_entry.data       = '0;
    push_entry.part       = PART_COMMAND;
    push_entry.packet_end = 1'b0;
    push_entry.fault_code = FAULT_NONE;
    if (accept && !cfg_write) begin
      push = 1'b1;
      if (halted) begin
        push_entry.kind       = KIND_FAULT;
        push_entry.fault_code = FAULT_HALTED;
      end else if (in_item.opcode) begin
        if (awaiting_ack) begin
          push_entry.kind       = KIND_FAULT;
          push_entry.fault_code = FAULT_REFUSED;
        end else begin
          push_entry.data = in_item.data_byte;
        end
      end else if (awaiting_ack) begin
        if (ack_index == 3'd0) begin
          if (in_item.data_byte != ACK_MARK) begin
            push_entry.kind       = KIND_FAULT;
            push_entry.fault_code = FAULT_MARKER;
          end else begin
            push = 1'b0;
          end
        end else if (ack_index >= ACK_LAST) begin
          push_entry.kind = KIND_ACK;
        end else begin
          push = 1'b0;
        end
      end else begin
        push_entry.ack_burst = rx_expire;
        push_entry.kind      = KIND_PACKET;
        push_entry.data      = in_item.data_byte;
        if (rx_phase == RX_HEADER) begin
          if (header_index != 3'd0) begin
            push_entry.part = PART_LENGTH;
            if (header_index >= HEADER_LAST) begin
              if (length_over) begin
                push_entry.kind       = KIND_FAULT;
                push_entry.data       = '0;
                push_entry.part       = PART_COMMAND;
                push_entry.fault_code = FAULT_LENGTH;
              end else begin
                push_entry.packet_end = length_acc == 32'd0;
              end
            end
          end
        end else begin
          push_entry.part       = PART_PAYLOAD;
          push_entry.packet_end = payload_remaining <= 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit      <= RESET_LENGTH_LIMIT;
      rx_ack_interval   <= RESET_RX_ACK_INTERVAL;
      rx_phase          <= RX_HEADER;
      header_index      <= '0;
      length_word       <= '0;
      payload_remaining <= '0;
      rx_ack_countdown  <= RESET_INITIAL_INTERVAL;
      tx_credit         <= RESET_INITIAL_INTERVAL;
      awaiting_ack      <= 1'b0;
      ack_index         <= '0;
      ack_value         <= '0;
      halted            <= 1'b0;
    end else begin
      length_limit      <= length_limit_next;
      rx_ack_interval   <= rx_ack_interval_next;
      rx_phase          <= rx_phase_next;
      header_index      <= header_index_next;
      length_word       <= length_word_next;
      payload_remaining <= payload_remaining_next;
      rx_ack_countdown  <= rx_ack_countdown_next;
      tx_credit         <= tx_credit_next;
      awaiting_ack      <= awaiting_ack_next;
      ack_index         <= ack_index_next;
      ack_value         <= ack_value_next;
      halted            <= halted_next;
    end
  end

endmodule

// ----- hw/rtl/cale_queue.sv -----
// Entry queue between the front end and the result sequencer.
// A small register FIFO with a registered fill count; depends on cale_pkg.
module cale_queue #(
  parameter int DEPTH = cale_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  cale_pkg::entry_t        push_entry,
  input  logic                    pop,
  output cale_pkg::entry_t        head,
  output cale_pkg::queue_status_t q_stat
);
  import cale_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == CW'(DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/cale_back.sv -----
// Result sequencer of the link endpoint: expands each queue entry into its acknowledge
// burst and final result, one transfer per cycle while out_stall is low. Depends on cale_pkg.
module cale_back (
  input  logic                    clk,
  input  logic                    rst,
  input  cale_pkg::entry_t        head,
  input  cale_pkg::queue_status_t q_stat,
  output logic                    pop,
  input  logic [31:0]             rx_ack_interval,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cale_pkg::out_item_t     out_item
);
  import cale_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [2:0] beat;
  logic       in_burst;
  logic       xfer;
  logic       final_xfer;

  assign in_burst   = cur.ack_burst && (beat < ACK_BEATS);
  assign xfer       = cur_valid && !out_stall;
  assign final_xfer = xfer && !in_burst;
  assign pop        = (!cur_valid || final_xfer) && !q_stat.empty;
  assign out_valid  = cur_valid;

  always_comb begin
    out_item.kind       = cur.kind;
    out_item.data       = cur.data;
    out_item.part       = cur.part;
    out_item.packet_end = cur.packet_end;
    out_item.fault_code = cur.fault_code;
    out_item.last       = 1'b1;
    if (in_burst) begin
      out_item.kind       = KIND_XMIT;
      out_item.part       = PART_COMMAND;
      out_item.packet_end = 1'b0;
      out_item.fault_code = FAULT_NONE;
      out_item.last       = 1'b0;
      case (beat)
        3'd1:    out_item.data = rx_ack_interval[7:0];
        3'd2:    out_item.data = rx_ack_interval[15:8];
        3'd3:    out_item.data = rx_ack_interval[23:16];
        3'd4:    out_item.data = rx_ack_interval[31:24];
        default: out_item.data = ACK_MARK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      beat      <= '0;
    end else if (final_xfer) begin
      cur_valid <= 1'b0;
    end else if (xfer) begin
      beat <= beat + 3'd1;
    end
  end

endmodule

// ----- hw/rtl/credit_ack_link_endpoint_unit.sv -----
// Top level of the credit/acknowledge link endpoint.
// Instantiates cale_front, cale_queue and cale_back; depends on cale_pkg.
//
// Usage: each input transfer carries one link byte, with opcode 0 for a byte
// received from the link and 1 for a byte to send. Each input transfer causes
// zero to six result transfers on the output channel, the final one flagged by
// last. A received byte that expires the receive countdown first yields the
// five acknowledge bytes (0xFF, then the interval little-endian) as link
// transmit results. Bytes of an incoming acknowledge yield no result until
// its last byte.
// Each item's first result passes through the queue and the sequencer's current
// entry register before it is presented on the output channel. Throughput:
// one input transfer per cycle while the receiver takes one result per cycle;
// an item with an acknowledge burst holds the output for the burst and its result.
// A queue of QUEUE_DEPTH entries decouples the two channels, and in_stall is
// raised only when that queue is full.
// Reset clears the queue and the link state and loads the register defaults.
// While out_stall is high the current result holds and the queue fills.
// Configuration writes are ready while in_valid is low and must be issued only
// while idle.
module credit_ack_link_endpoint_unit #(
  parameter int QUEUE_DEPTH = cale_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cale_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cale_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cale_pkg::*;

  queue_status_t q_stat;
  logic          q_push;
  logic          q_pop;
  entry_t        push_entry;
  entry_t        head;
  logic [31:0]   rx_ack_interval;

  cale_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_stat          (q_stat),
    .push            (q_push),
    .push_entry      (push_entry),
    .rx_ack_interval (rx_ack_interval)
  );

  cale_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  cale_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (q_pop),
    .rx_ack_interval (rx_ack_interval),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

`ifndef SYNTHESIS
  // After reset the queue is empty and nothing is pending on the output.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output or stall active right after reset");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reported full and empty at once");

  // Finishing the last result with nothing queued leaves the output idle.
  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_item.last && q_stat.empty && !q_push) |=> !out_valid)
    else $error("output valid without a queued entry");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for credit_ack_link_endpoint_unit: directed rows, then
// random packet, send and acknowledge traffic under several register settings,
// ending in a forced halt. Depends on cale_pkg and the block's RTL only.
module tb_top;
  import cale_pkg::*;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_SEND = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 100;

  typedef enum logic {
    STEP_ITEM,
    STEP_SETTINGS
  } step_e;

  typedef struct {
    step_e       step;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
    logic [31:0] start_credit;
    logic [31:0] ack_every;
    logic [31:0] max_length;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predicted state of the endpoint.
  logic [31:0] cfg_start_credit = RESET_INITIAL_INTERVAL;
  logic [31:0] cfg_ack_every = RESET_RX_ACK_INTERVAL;
  logic [31:0] cfg_max_length = RESET_LENGTH_LIMIT;
  rx_phase_t   rx_state = RX_HEADER;
  logic [2:0]  hdr_pos = '0;
  logic [31:0] len_acc = '0;
  logic [31:0] payload_left = '0;
  logic [31:0] ack_countdown = RESET_INITIAL_INTERVAL;
  logic [31:0] credit = RESET_INITIAL_INTERVAL;
  logic        waiting_ack = 1'b0;
  logic [2:0]  ack_pos = '0;
  logic [31:0] ack_acc = '0;
  logic        stopped = 1'b0;

  out_item_t   link_results[$];

  // Traffic shaping.
  logic [31:0] len_plan = '0;
  logic [31:0] ack_plan = '0;
  int          send_share = 30;
  bit          no_idle = 1'b0;
  fault_t      halt_goal = FAULT_NONE;

  int mismatches = 0;
  int results_checked = 0;
  int transfers_in = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int stall_left = 0;

  credit_ack_link_endpoint_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic out_item_t make_result(kind_t k, logic [7:0] d, part_t p, logic e,
                                            fault_t f, logic l);
    out_item_t r;
    r.kind = k;
    r.data = d;
    r.part = p;
    r.packet_end = e;
    r.fault_code = f;
    r.last = l;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Keeps a length that is already half sent within the new limit.
  function automatic logic [31:0] safe_limit(logic [31:0] lim);
    if (rx_state == RX_HEADER && hdr_pos != 0 && len_plan > lim) return len_plan;
    return lim;
  endfunction

  task automatic predict_link(input in_item_t it);
    out_item_t produced[$];
    logic [7:0] b;
    b = it.data_byte;
    if (stopped) begin
      produced.push_back(make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_HALTED, 1'b0));
    end else if (it.opcode == OP_SEND) begin
      if (waiting_ack) begin
        produced.push_back(make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_REFUSED,
                                       1'b0));
      end else begin
        produced.push_back(make_result(KIND_XMIT, b, PART_COMMAND, 1'b0, FAULT_NONE, 1'b0));
        if (credit <= 1) begin
          credit = '0;
          waiting_ack = 1'b1;
          ack_pos = '0;
        end else begin
          credit--;
        end
      end
    end else if (waiting_ack) begin
      if (ack_pos == 0) begin
        if (b != ACK_MARK) begin
          stopped = 1'b1;
          produced.push_back(make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_MARKER,
                                         1'b0));
        end else begin
          ack_acc = '0;
          ack_pos = 3'd1;
        end
      end else begin
        ack_acc[8*(int'(ack_pos)-1) +: 8] = b;
        if (ack_pos >= ACK_LAST) begin
          ack_pos = '0;
          credit = ack_acc;
          if (credit != 0) waiting_ack = 1'b0;
          produced.push_back(make_result(KIND_ACK, 8'h00, PART_COMMAND, 1'b0, FAULT_NONE, 1'b0));
        end else begin
          ack_pos++;
        end
      end
    end else begin
      if (ack_countdown <= 1) begin
        ack_countdown = cfg_ack_every;
        produced.push_back(make_result(KIND_XMIT, ACK_MARK, PART_COMMAND, 1'b0, FAULT_NONE,
                                       1'b0));
        for (int k = 0; k < 4; k++) begin
          produced.push_back(make_result(KIND_XMIT, cfg_ack_every[8*k +: 8], PART_COMMAND, 1'b0,
                                         FAULT_NONE, 1'b0));
        end
      end else begin
        ack_countdown--;
      end
      if (rx_state == RX_HEADER) begin
        if (hdr_pos == 0) begin
          len_acc = '0;
          hdr_pos = 3'd1;
          produced.push_back(make_result(KIND_PACKET, b, PART_COMMAND, 1'b0, FAULT_NONE, 1'b0));
        end else begin
          len_acc[8*(int'(hdr_pos)-1) +: 8] = b;
          if (hdr_pos < HEADER_LAST) begin
            hdr_pos++;
            produced.push_back(make_result(KIND_PACKET, b, PART_LENGTH, 1'b0, FAULT_NONE, 1'b0));
          end else begin
            hdr_pos = '0;
            if (len_acc > cfg_max_length) begin
              stopped = 1'b1;
              produced.push_back(make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_LENGTH,
                                             1'b0));
            end else if (len_acc == 0) begin
              produced.push_back(make_result(KIND_PACKET, b, PART_LENGTH, 1'b1, FAULT_NONE,
                                             1'b0));
            end else begin
              payload_left = len_acc;
              rx_state = RX_PAYLOAD;
              produced.push_back(make_result(KIND_PACKET, b, PART_LENGTH, 1'b0, FAULT_NONE,
                                             1'b0));
            end
          end
        end
      end else if (payload_left <= 1) begin
        payload_left = '0;
        rx_state = RX_HEADER;
        produced.push_back(make_result(KIND_PACKET, b, PART_PAYLOAD, 1'b1, FAULT_NONE, 1'b0));
      end else begin
        payload_left--;
        produced.push_back(make_result(KIND_PACKET, b, PART_PAYLOAD, 1'b0, FAULT_NONE, 1'b0));
      end
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) link_results.push_back(produced[i]);
  endtask

  task automatic apply_setting(input cfg_index_t idx, input logic [31:0] v);
    case (idx)
      CFG_INITIAL_INTERVAL: begin
        cfg_start_credit = v;
        credit = v;
        ack_countdown = v;
      end
      CFG_RX_ACK_INTERVAL: begin
        cfg_ack_every = v;
      end
      CFG_LENGTH_LIMIT: begin
        cfg_max_length = v;
      end
      default: begin
      end
    endcase
  endtask

  // Picks the next input from the predicted state so that most traffic forms
  // whole packets and acknowledges with random content.
  function automatic in_item_t shaped_item();
    in_item_t it;
    int r;
    it.opcode = OP_RECEIVE;
    it.data_byte = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (waiting_ack) begin
      if (halt_goal == FAULT_NONE && r < 8) begin
        it.opcode = OP_SEND;
      end else if (ack_pos == 0) begin
        if (halt_goal == FAULT_MARKER) begin
          it.data_byte = 8'($urandom_range(0, 254));
        end else begin
          it.data_byte = ACK_MARK;
          r = $urandom_range(0, 99);
          if (halt_goal == FAULT_NONE && r < 10) ack_plan = '0;
          else if (halt_goal == FAULT_NONE && r < 13) ack_plan = $urandom;
          else ack_plan = $urandom_range(1, 24);
        end
      end else begin
        it.data_byte = ack_plan[8*(int'(ack_pos)-1) +: 8];
      end
    end else if (halt_goal == FAULT_MARKER || (halt_goal == FAULT_NONE && r < send_share)) begin
      it.opcode = OP_SEND;
    end else if (rx_state == RX_HEADER && hdr_pos == 0) begin
      if (halt_goal == FAULT_LENGTH) begin
        len_plan = cfg_max_length + 1 + $urandom_range(0, 32'hFFFF0000);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) len_plan = $urandom_range(0, 4);
        else if (r < 95) len_plan = $urandom_range(5, 24);
        else len_plan = $urandom_range(25, 60);
        if (len_plan > cfg_max_length) len_plan = cfg_max_length;
      end
    end else if (rx_state == RX_HEADER) begin
      it.data_byte = len_plan[8*(int'(hdr_pos)-1) +: 8];
    end
    return it;
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    int before_count;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfers_in++;
    before_count = link_results.size();
    predict_link(it);
    if (typed) begin
      while (link_results.size() > before_count) void'(link_results.pop_back());
      link_results.push_back(want);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (link_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [31:0] start_credit, input logic [31:0] ack_every,
                                input logic [31:0] max_length);
    cfg_index_t  regs[3];
    logic [31:0] vals[3];
    regs = '{CFG_INITIAL_INTERVAL, CFG_RX_ACK_INTERVAL, CFG_LENGTH_LIMIT};
    vals = '{start_credit, ack_every, max_length};
    wait_for_drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_setting(regs[i], vals[i]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t item_row(logic op, logic [7:0] b);
    plan_row_t row;
    row.step = STEP_ITEM;
    row.item.opcode = op;
    row.item.data_byte = b;
    row.typed = 1'b0;
    row.want = '0;
    row.start_credit = '0;
    row.ack_every = '0;
    row.max_length = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic op, logic [7:0] b, out_item_t want);
    plan_row_t row;
    row = item_row(op, b);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t settings_row(logic [31:0] a, logic [31:0] e, logic [31:0] m);
    plan_row_t row;
    row = item_row(OP_RECEIVE, 8'h00);
    row.step = STEP_SETTINGS;
    row.start_credit = a;
    row.ack_every = e;
    row.max_length = m;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_result;
    if (!rst && out_valid && !out_stall) begin
      if (link_results.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d data %0d",
               out_item.kind, out_item.data);
        mismatches++;
      end else begin
        exp_result = link_results.pop_front();
        results_checked++;
        check_field("kind", 8'(exp_result.kind), 8'(out_item.kind));
        check_field("data", exp_result.data, out_item.data);
        check_field("part", 8'(exp_result.part), 8'(out_item.part));
        check_field("packet_end", 8'(exp_result.packet_end), 8'(out_item.packet_end));
        check_field("fault_code", 8'(exp_result.fault_code), 8'(out_item.fault_code));
        check_field("last", 8'(exp_result.last), 8'(out_item.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    in_item_t  it;
    logic [31:0] lim;

    // Reset values first, then a zero receive interval and a one-byte credit.
    plan.push_back(typed_row(OP_SEND, 8'h00,
      make_result(KIND_XMIT, 8'h00, PART_COMMAND, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_PACKET, 8'h00, PART_COMMAND, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_PACKET, 8'h00, PART_LENGTH, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_PACKET, 8'h00, PART_LENGTH, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_PACKET, 8'h00, PART_LENGTH, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_PACKET, 8'h00, PART_LENGTH, 1'b1, FAULT_NONE, 1'b1)));
    plan.push_back(item_row(OP_RECEIVE, 8'hC3));
    plan.push_back(item_row(OP_RECEIVE, 8'h01));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(item_row(OP_RECEIVE, 8'h5A));
    plan.push_back(settings_row(32'd1, 32'd0, 32'hFFFF_FFFF));
    plan.push_back(item_row(OP_RECEIVE, 8'h3C));
    plan.push_back(typed_row(OP_SEND, 8'h81,
      make_result(KIND_XMIT, 8'h81, PART_COMMAND, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(typed_row(OP_SEND, 8'h7E,
      make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_REFUSED, 1'b1)));
    plan.push_back(item_row(OP_RECEIVE, ACK_MARK));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(item_row(OP_RECEIVE, 8'h00));
    plan.push_back(typed_row(OP_RECEIVE, 8'h00,
      make_result(KIND_ACK, 8'h00, PART_COMMAND, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(item_row(OP_RECEIVE, ACK_MARK));
    plan.push_back(item_row(OP_RECEIVE, 8'hFF));
    plan.push_back(item_row(OP_RECEIVE, 8'hFF));
    plan.push_back(item_row(OP_RECEIVE, 8'hFF));
    plan.push_back(typed_row(OP_RECEIVE, 8'hFF,
      make_result(KIND_ACK, 8'h00, PART_COMMAND, 1'b0, FAULT_NONE, 1'b1)));
    plan.push_back(item_row(OP_SEND, 8'hFF));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].step == STEP_SETTINGS) begin
        write_settings(plan[i].start_credit, plan[i].ack_every, plan[i].max_length);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_settings(32'd1, 32'd1, safe_limit(32'd0));
        1: write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: begin
          lim = safe_limit($urandom_range(0, 30));
          write_settings($urandom_range(1, 12), $urandom_range(1, 20), lim);
        end
      endcase
      no_idle = (ph == 2);
      send_share = $urandom_range(15, 45);
      repeat (ITEMS_PER_PHASE) begin
        push_item(shaped_item(), 1'b0, '0);
        if ($urandom_range(0, 49) == 0) wait_for_drain();
      end
    end
    no_idle = 1'b0;

    // Drive the link into a halt and confirm that it stays there.
    lim = safe_limit($urandom_range(0, 64));
    write_settings($urandom_range(1, 3), $urandom_range(1, 20), lim);
    halt_goal = ($urandom_range(0, 1) == 0) ? FAULT_LENGTH : FAULT_MARKER;
    while (!stopped) push_item(shaped_item(), 1'b0, '0);
    repeat (4) begin
      it.opcode = 1'($urandom_range(0, 1));
      it.data_byte = 8'($urandom_range(0, 255));
      push_item(it, 1'b1, make_result(KIND_FAULT, 8'h00, PART_COMMAND, 1'b0, FAULT_HALTED, 1'b1));
    end

    wait_for_drain();
    $display("Covered %0d input transfers and %0d checked results across %0d register writes.",
             transfers_in, results_checked, reg_writes);
    $display("The link was finally halted by %s.",
             (halt_goal == FAULT_LENGTH) ? "an oversized length" : "a bad acknowledge marker");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cale_pkg.sv
hw/rtl/cale_front.sv
hw/rtl/cale_queue.sv
hw/rtl/cale_back.sv
hw/rtl/credit_ack_link_endpoint_unit.sv
test/tb_top.sv
